/* hdl/rfbd_pkg.sv */
// ----------------------------------------------------------------------------
// rfbd_pkg: shared types and constants for the RLE frame blit decoder
// Beat payloads, action and register codes, field widths and reset values.
// ----------------------------------------------------------------------------
package rfbd_pkg;

    // Fixed field widths
    localparam int ADDR_BITS      = 20;
    localparam int COUNT_BITS     = 12;
    localparam int COLOR_BITS     = 16;
    localparam int CFG_DATA_BITS  = 20;
    localparam int CFG_INDEX_BITS = 3;
    localparam int DIM_BITS       = 12;
    localparam int PITCH_BITS     = 13;
    localparam int RUN_BITS       = 16;

    // Defaults and limits
    localparam int MAX_WIDTH_DEFAULT = 2048;
    localparam int HEIGHT_LIMIT      = 2048;

    // Register reset values
    localparam int RESET_PICTURE_WIDTH  = 428;
    localparam int RESET_PICTURE_HEIGHT = 320;
    localparam int RESET_LINE_PITCH     = 528;
    localparam int RESET_ORIGIN_ADDRESS = 50;
    localparam logic RESET_BINARY_MODE  = 1'b1;
    localparam logic RESET_VARINT_MODE  = 1'b1;

    // Token stream constants
    localparam logic [7:0]            VARINT_MORE_MASK = 8'h80;
    localparam logic [7:0]            VARINT_LOW_MASK  = 8'h7F;
    localparam logic [COLOR_BITS-1:0] COLOR_BLACK      = 16'h0000;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PICTURE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PICTURE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LINE_PITCH     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_ADDRESS = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BINARY_MODE    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VARINT_MODE    = 3'd5;

    typedef enum logic [1:0] {
        ACT_START    = 2'd0,
        ACT_DATA     = 2'd1,
        ACT_END      = 2'd2,
        ACT_CONTINUE = 2'd3
    } action_t;

    typedef struct packed {
        action_t    action;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0]  write_address;
        logic [COUNT_BITS-1:0] pixel_count;
        logic [COLOR_BITS-1:0] pixel_color;
        logic                  more_pending;
        logic                  frame_done;
    } result_t;

endpackage

/* hdl/rle_frame_blit_decoder.sv */
// ----------------------------------------------------------------------------
// rle_frame_blit_decoder: run-length token decoder to framebuffer row writes
// Parses one frame's token stream a byte per beat and emits row segments.
// ----------------------------------------------------------------------------
// The block takes one item beat per clock and returns at most one segment beat
// for it. All parsing, clipping and address stepping for an item is done in
// the cycle it is accepted, and the segment lands in an output register with
// a one-entry skid stage behind it, so item stall rises only while two
// segments wait on a stalled output. A start item resets the cursor and loads
// the frame size (width times height, one multiply); each run that is not empty
// after clipping gives its first segment on the byte that completes its token,
// and every further segment of a run needs one continue item.
module rle_frame_blit_decoder
    import rfbd_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Configuration write port
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    // Item channel
    input  logic                      item_valid,
    output logic                      item_stall,
    input  item_t                     item,
    // Segment channel
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_t                   result
);

    localparam int RB        = $clog2(MAX_WIDTH + 1);
    localparam int WC        = (RB > DIM_BITS) ? RB : DIM_BITS;
    localparam int FPL_BITS  = $clog2(MAX_WIDTH * HEIGHT_LIMIT + 1);
    localparam int LEN_BITS  = (FPL_BITS > RUN_BITS) ? FPL_BITS : RUN_BITS;
    localparam int PROD_BITS = RB + DIM_BITS;
    localparam int RESET_ROW = (RESET_PICTURE_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                                 : RESET_PICTURE_WIDTH;

    typedef enum logic [1:0] {
        PH_LEN_FIRST,
        PH_LEN_SECOND,
        PH_COLOR_LOW,
        PH_COLOR_HIGH
    } phase_t;

    // Configuration registers
    logic [DIM_BITS-1:0]   width_reg;
    logic [DIM_BITS-1:0]   height_reg;
    logic [PITCH_BITS-1:0] pitch_reg;
    logic [ADDR_BITS-1:0]  origin_reg;
    logic                  binary_reg;
    logic                  varint_reg;

    // Decoder state
    phase_t                phase_reg, phase_next;
    logic [7:0]            held_reg, held_next;
    logic [RUN_BITS-1:0]   run_len_reg, run_len_next;
    logic [FPL_BITS-1:0]   pending_reg, pending_next;
    logic [COLOR_BITS-1:0] run_color_reg, run_color_next;
    logic [COLOR_BITS-1:0] alt_reg, alt_next;
    logic [ADDR_BITS-1:0]  cursor_reg, cursor_next;
    logic [RB-1:0]         row_reg, row_next;
    logic [FPL_BITS-1:0]   fpl_reg, fpl_next;

    // Output register and skid stage
    result_t               head_reg, skid_reg;
    logic                  head_valid_reg, skid_valid_reg;

    // Working signals
    logic                  item_accept;
    logic                  result_pop;
    logic [WC-1:0]         w_wide;
    logic [RB-1:0]         w_eff;
    logic [DIM_BITS-1:0]   h_eff;
    logic [PROD_BITS-1:0]  frame_size;
    logic                  length_done;
    logic [RUN_BITS-1:0]   len_tok;
    logic                  start;
    logic                  cont;
    logic [LEN_BITS-1:0]   run_len_src;
    logic [COLOR_BITS-1:0] color_src;
    logic [FPL_BITS-1:0]   clipped;
    logic [FPL_BITS-1:0]   fpl_after;
    logic [FPL_BITS-1:0]   pend_src;
    logic                  emit;
    logic [RB-1:0]         row_eff;
    logic [RB-1:0]         seg_len;
    logic [WC-1:0]         seg_wide;
    logic [RB-1:0]         row_after;
    logic [FPL_BITS-1:0]   pend_after;
    logic [ADDR_BITS-1:0]  cursor_step;
    logic [ADDR_BITS-1:0]  cursor_wrap;
    result_t               seg;

    assign item_accept  = item_valid && !item_stall;
    assign item_stall   = skid_valid_reg;
    assign result_pop   = head_valid_reg && !result_stall;
    assign result_valid = head_valid_reg;
    assign result       = head_reg;

    // Clamp the picture size to the supported range
    always_comb
    begin
        w_wide = WC'(width_reg);
        if (w_wide == '0)
        begin
            w_wide = WC'(1);
        end
        else if (w_wide > WC'(MAX_WIDTH))
        begin
            w_wide = WC'(MAX_WIDTH);
        end
        w_eff = w_wide[RB-1:0];
        h_eff = (height_reg > DIM_BITS'(HEIGHT_LIMIT)) ? DIM_BITS'(HEIGHT_LIMIT)
                                                        : height_reg;
    end

    assign frame_size = PROD_BITS'(w_eff) * PROD_BITS'(h_eff);

    // Decode the item, start runs and cut the next segment
    always_comb
    begin
        phase_next     = phase_reg;
        held_next      = held_reg;
        run_len_next   = run_len_reg;
        pending_next   = pending_reg;
        run_color_next = run_color_reg;
        alt_next       = alt_reg;
        cursor_next    = cursor_reg;
        row_next       = row_reg;
        fpl_next       = fpl_reg;
        length_done    = 1'b0;
        len_tok        = '0;
        start          = 1'b0;
        cont           = 1'b0;
        run_len_src    = '0;
        color_src      = COLOR_BLACK;

        if (item_accept)
        begin
            unique case (item.action)
                ACT_START:
                begin
                    phase_next   = PH_LEN_FIRST;
                    held_next    = '0;
                    run_len_next = '0;
                    pending_next = '0;
                    alt_next     = COLOR_BLACK;
                    cursor_next  = origin_reg;
                    row_next     = w_eff;
                    fpl_next     = frame_size[FPL_BITS-1:0];
                end
                ACT_DATA:
                begin
                    if (pending_reg == '0 && fpl_reg != '0)
                    begin
                        case (phase_reg)
                            PH_LEN_FIRST:
                            begin
                                if (varint_reg
                                    && (item.data_byte & VARINT_MORE_MASK) == 8'h00)
                                begin
                                    len_tok     = RUN_BITS'(item.data_byte);
                                    length_done = 1'b1;
                                end
                                else
                                begin
                                    held_next  = item.data_byte;
                                    phase_next = PH_LEN_SECOND;
                                end
                            end
                            PH_LEN_SECOND:
                            begin
                                if (varint_reg)
                                begin
                                    len_tok = {1'b0, held_reg[6:0] & VARINT_LOW_MASK[6:0],
                                               item.data_byte};
                                end
                                else
                                begin
                                    len_tok = {item.data_byte, held_reg};
                                end
                                length_done = 1'b1;
                            end
                            PH_COLOR_LOW:
                            begin
                                held_next  = item.data_byte;
                                phase_next = PH_COLOR_HIGH;
                            end
                            default:
                            begin
                                phase_next  = PH_LEN_FIRST;
                                start       = 1'b1;
                                run_len_src = LEN_BITS'(run_len_reg);
                                color_src   = {item.data_byte, held_reg};
                            end
                        endcase
                    end
                end
                ACT_END:
                begin
                    if (pending_reg == '0)
                    begin
                        phase_next = PH_LEN_FIRST;
                        if (fpl_reg != '0)
                        begin
                            start       = 1'b1;
                            run_len_src = LEN_BITS'(fpl_reg);
                            color_src   = COLOR_BLACK;
                        end
                    end
                end
                default:
                begin
                    cont = (pending_reg != '0);
                end
            endcase
        end

        // Finish a length token: wait for colour or take the alternating one
        if (length_done)
        begin
            run_len_next = len_tok;
            if (!binary_reg)
            begin
                phase_next = PH_COLOR_LOW;
            end
            else
            begin
                phase_next  = PH_LEN_FIRST;
                start       = 1'b1;
                run_len_src = LEN_BITS'(len_tok);
                color_src   = alt_reg;
                alt_next    = ~alt_reg;
            end
        end

        // Clip the run to the pixels left in the frame
        clipped   = (run_len_src < LEN_BITS'(fpl_reg)) ? run_len_src[FPL_BITS-1:0]
                                                       : fpl_reg;
        fpl_after = start ? (fpl_reg - clipped) : fpl_reg;
        pend_src  = start ? clipped : pending_reg;
        emit      = start ? (clipped != '0) : cont;

        if (start)
        begin
            fpl_next       = fpl_after;
            pending_next   = clipped;
            run_color_next = color_src;
        end

        // Cut one segment within the current row
        row_eff     = (row_reg == '0) ? w_eff : row_reg;
        seg_len     = (FPL_BITS'(row_eff) < pend_src) ? row_eff : pend_src[RB-1:0];
        seg_wide    = WC'(seg_len);
        row_after   = row_eff - seg_len;
        pend_after  = pend_src - FPL_BITS'(seg_len);
        cursor_step = cursor_reg + ADDR_BITS'(seg_len);
        cursor_wrap = cursor_step + ADDR_BITS'(pitch_reg) - ADDR_BITS'(w_eff);

        seg.write_address = cursor_reg;
        seg.pixel_count   = seg_wide[COUNT_BITS-1:0];
        seg.pixel_color   = start ? color_src : run_color_reg;
        seg.more_pending  = (pend_after != '0);
        seg.frame_done    = (pend_after == '0) && (fpl_after == '0);

        if (emit)
        begin
            pending_next = pend_after;
            if (row_after == '0 && (pend_after != '0 || fpl_after != '0))
            begin
                cursor_next = cursor_wrap;
                row_next    = w_eff;
            end
            else
            begin
                cursor_next = cursor_step;
                row_next    = row_after;
            end
        end
    end

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_BITS'(RESET_PICTURE_WIDTH);
            height_reg <= DIM_BITS'(RESET_PICTURE_HEIGHT);
            pitch_reg  <= PITCH_BITS'(RESET_LINE_PITCH);
            origin_reg <= ADDR_BITS'(RESET_ORIGIN_ADDRESS);
            binary_reg <= RESET_BINARY_MODE;
            varint_reg <= RESET_VARINT_MODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PICTURE_WIDTH:  width_reg  <= cfg_data[DIM_BITS-1:0];
                CFG_PICTURE_HEIGHT: height_reg <= cfg_data[DIM_BITS-1:0];
                CFG_LINE_PITCH:     pitch_reg  <= cfg_data[PITCH_BITS-1:0];
                CFG_ORIGIN_ADDRESS: origin_reg <= cfg_data[ADDR_BITS-1:0];
                CFG_BINARY_MODE:    binary_reg <= cfg_data[0];
                CFG_VARINT_MODE:    varint_reg <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Advance decoder state and the output buffer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_LEN_FIRST;
            held_reg       <= '0;
            run_len_reg    <= '0;
            pending_reg    <= '0;
            run_color_reg  <= COLOR_BLACK;
            alt_reg        <= COLOR_BLACK;
            cursor_reg     <= ADDR_BITS'(RESET_ORIGIN_ADDRESS);
            row_reg        <= RB'(RESET_ROW);
            fpl_reg        <= '0;
            head_reg       <= '0;
            skid_reg       <= '0;
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            held_reg      <= held_next;
            run_len_reg   <= run_len_next;
            pending_reg   <= pending_next;
            run_color_reg <= run_color_next;
            alt_reg       <= alt_next;
            cursor_reg    <= cursor_next;
            row_reg       <= row_next;
            fpl_reg       <= fpl_next;

            // Refill the head from the skid stage or take the new segment beat
            if (result_pop)
            begin
                if (skid_valid_reg)
                begin
                    head_reg       <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    head_reg       <= seg;
                    head_valid_reg <= emit;
                end
            end
            else if (!head_valid_reg)
            begin
                head_reg       <= seg;
                head_valid_reg <= emit;
            end
            else if (emit)
            begin
                skid_reg       <= seg;
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Skid stage only fills behind a waiting head
    a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> head_valid_reg)
        else $error("skid stage holds a beat while the head is empty");

    // A draining skid stage leaves the head full
    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !result_stall) |=> (head_valid_reg && !skid_valid_reg))
        else $error("skid beat lost on drain");

    // Pending segments only exist between tokens
    a_pending_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (pending_reg != '0) |-> (phase_reg == PH_LEN_FIRST))
        else $error("segments pending inside a partial token");

    // A segment flagged as having more leaves pixels pending
    a_more_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && seg.more_pending) |=> (pending_reg != '0))
        else $error("more_pending set but nothing left pending");

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the RLE frame blit decoder
// Decodes token streams in a mirror model of the decoder and matches every
// segment beat against it. Covers both length codings, both colour schemes,
// clipping, end padding, odd frame sizes, address wrap and output backpressure.
// ----------------------------------------------------------------------------
module tb;
    import rfbd_pkg::*;

    localparam int PIX_BITS      = 23;
    localparam int RANDOM_ITEMS  = 330;
    localparam int TAIL_CYCLES   = 10;
    localparam int HOLD_CYCLES   = 80;
    localparam int TIMEOUT_NS    = 3_000_000;
    localparam logic [DIM_BITS-1:0] WIDTH_CAP = DIM_BITS'(MAX_WIDTH_DEFAULT);

    typedef enum logic [1:0] {
        EXPECT_LEN_FIRST,
        EXPECT_LEN_SECOND,
        EXPECT_RGB_LOW,
        EXPECT_RGB_HIGH
    } tok_phase_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      item_valid;
    logic                      item_stall;
    item_t                     item;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    result_t                   result;

    // register copies
    logic [DIM_BITS-1:0]   cfg_width;
    logic [DIM_BITS-1:0]   cfg_height;
    logic [PITCH_BITS-1:0] cfg_pitch;
    logic [ADDR_BITS-1:0]  cfg_origin;
    logic                  cfg_binary;
    logic                  cfg_varint;

    // decoder state copies
    tok_phase_t            tok_phase;
    logic [7:0]            tok_held;
    logic [RUN_BITS-1:0]   tok_len;
    logic [PIX_BITS-1:0]   pend_px;
    logic [COLOR_BITS-1:0] run_rgb;
    logic [COLOR_BITS-1:0] alt_rgb;
    logic [ADDR_BITS-1:0]  cursor;
    logic [DIM_BITS-1:0]   row_room;
    logic [PIX_BITS-1:0]   frame_left;

    result_t segments_due[$];

    int  errors         = 0;
    int  items_used     = 0;
    int  segments_seen  = 0;
    int  frames_started = 0;
    int  hold_request   = 0;
    int  hold_left      = 0;
    bit  steady         = 1'b0;

    rle_frame_blit_decoder i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Mirror model of the decoder
    // ------------------------------------------------------------------
    function automatic logic [DIM_BITS-1:0] eff_width();
        if (cfg_width == 0)
            return DIM_BITS'(1);
        if (cfg_width > WIDTH_CAP)
            return WIDTH_CAP;
        return cfg_width;
    endfunction

    function automatic logic [DIM_BITS-1:0] eff_height();
        if (cfg_height > HEIGHT_LIMIT)
            return DIM_BITS'(HEIGHT_LIMIT);
        return cfg_height;
    endfunction

    function automatic void reset_model();
        cfg_width  = DIM_BITS'(RESET_PICTURE_WIDTH);
        cfg_height = DIM_BITS'(RESET_PICTURE_HEIGHT);
        cfg_pitch  = PITCH_BITS'(RESET_LINE_PITCH);
        cfg_origin = ADDR_BITS'(RESET_ORIGIN_ADDRESS);
        cfg_binary = RESET_BINARY_MODE;
        cfg_varint = RESET_VARINT_MODE;
        tok_phase  = EXPECT_LEN_FIRST;
        tok_held   = '0;
        tok_len    = '0;
        pend_px    = '0;
        run_rgb    = '0;
        alt_rgb    = COLOR_BLACK;
        cursor     = cfg_origin;
        row_room   = eff_width();
        frame_left = '0;
    endfunction

    // Cut the next row segment off the pending run and queue it
    function automatic void emit_segment();
        logic [DIM_BITS-1:0] w;
        logic [DIM_BITS-1:0] n;
        result_t             seg;
        w = eff_width();
        if (row_room == 0)
            row_room = w;
        n = (PIX_BITS'(row_room) < pend_px) ? row_room : pend_px[DIM_BITS-1:0];
        seg.write_address = cursor;
        seg.pixel_count   = n;
        seg.pixel_color   = run_rgb;
        cursor   = cursor + ADDR_BITS'(n);
        row_room = row_room - n;
        pend_px  = pend_px - PIX_BITS'(n);
        // step to the next row once this one is full and more is to come
        if (row_room == 0 && (pend_px != 0 || frame_left != 0))
        begin
            cursor   = cursor + ADDR_BITS'(cfg_pitch) - ADDR_BITS'(w);
            row_room = w;
        end
        seg.more_pending = (pend_px != 0);
        seg.frame_done   = (pend_px == 0 && frame_left == 0);
        segments_due.push_back(seg);
    endfunction

    function automatic void start_run(logic [PIX_BITS-1:0] len, logic [COLOR_BITS-1:0] rgb);
        logic [PIX_BITS-1:0] clipped;
        clipped    = (len < frame_left) ? len : frame_left;
        frame_left = frame_left - clipped;
        pend_px    = clipped;
        run_rgb    = rgb;
        if (clipped != 0)
            emit_segment();
    endfunction

    function automatic void length_done();
        logic [COLOR_BITS-1:0] rgb;
        if (!cfg_binary)
            tok_phase = EXPECT_RGB_LOW;
        else
        begin
            tok_phase = EXPECT_LEN_FIRST;
            rgb       = alt_rgb;
            alt_rgb   = ~alt_rgb;
            start_run(PIX_BITS'(tok_len), rgb);
        end
    endfunction

    function automatic void take_byte(logic [7:0] b);
        case (tok_phase)
            EXPECT_LEN_FIRST:
                if (cfg_varint && (b & VARINT_MORE_MASK) == 0)
                begin
                    tok_len = RUN_BITS'(b);
                    length_done();
                end
                else
                begin
                    tok_held  = b;
                    tok_phase = EXPECT_LEN_SECOND;
                end
            EXPECT_LEN_SECOND:
            begin
                if (cfg_varint)
                    tok_len = {tok_held & VARINT_LOW_MASK, b};
                else
                    tok_len = {b, tok_held};
                length_done();
            end
            EXPECT_RGB_LOW:
            begin
                tok_held  = b;
                tok_phase = EXPECT_RGB_HIGH;
            end
            default:
            begin
                tok_phase = EXPECT_LEN_FIRST;
                start_run(PIX_BITS'(tok_len), {b, tok_held});
            end
        endcase
    endfunction

    // Advance the model by one accepted item; flag whether it did anything
    function automatic void decode_item(item_t it, output bit used);
        used = 1'b1;
        case (it.action)
            ACT_START:
            begin
                tok_phase  = EXPECT_LEN_FIRST;
                tok_held   = '0;
                tok_len    = '0;
                pend_px    = '0;
                alt_rgb    = COLOR_BLACK;
                cursor     = cfg_origin;
                row_room   = eff_width();
                frame_left = PIX_BITS'(eff_width()) * PIX_BITS'(eff_height());
            end
            ACT_DATA:
                if (pend_px != 0 || frame_left == 0)
                    used = 1'b0;
                else
                    take_byte(it.data_byte);
            ACT_END:
                if (pend_px != 0)
                    used = 1'b0;
                else
                begin
                    tok_phase = EXPECT_LEN_FIRST;
                    if (frame_left == 0)
                        used = 1'b0;
                    else
                        start_run(frame_left, COLOR_BLACK);
                end
            default:
                if (pend_px == 0)
                    used = 1'b0;
                else
                    emit_segment();
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Item side
    // ------------------------------------------------------------------
    task automatic send_item(input action_t act, input logic [7:0] b);
        item_t it;
        bit    used;
        it.action    = act;
        it.data_byte = b;
        @(negedge clk);
        // random gaps between beats
        while (!steady && $urandom_range(0, 99) < 6)
        begin
            item_valid = 1'b0;
            @(negedge clk);
        end
        item_valid = 1'b1;
        item       = it;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        decode_item(it, used);
        if (used)
            items_used++;
    endtask

    // Drop valid and wait until every queued segment has come back
    task automatic settle();
        @(negedge clk);
        item_valid = 1'b0;
        while (segments_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned val);
        @(negedge clk);
        item_valid = 1'b0;
        cfg_we     = 1'b1;
        cfg_index  = idx;
        cfg_data   = CFG_DATA_BITS'(val);
        case (idx)
            CFG_PICTURE_WIDTH:  cfg_width  = DIM_BITS'(val);
            CFG_PICTURE_HEIGHT: cfg_height = DIM_BITS'(val);
            CFG_LINE_PITCH:     cfg_pitch  = PITCH_BITS'(val);
            CFG_ORIGIN_ADDRESS: cfg_origin = ADDR_BITS'(val);
            CFG_BINARY_MODE:    cfg_binary = val[0];
            CFG_VARINT_MODE:    cfg_varint = val[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic set_picture(input int w, input int h, input int pitch, input int origin,
                               input int binary, input int varint);
        settle();
        write_reg(CFG_PICTURE_WIDTH, w);
        write_reg(CFG_PICTURE_HEIGHT, h);
        write_reg(CFG_LINE_PITCH, pitch);
        write_reg(CFG_ORIGIN_ADDRESS, origin);
        write_reg(CFG_BINARY_MODE, binary);
        write_reg(CFG_VARINT_MODE, varint);
    endtask

    // Encode one run token in the current coding
    task automatic send_run(input logic [RUN_BITS-1:0] len, input logic [COLOR_BITS-1:0] rgb);
        if (cfg_varint)
        begin
            if (len < 128 && $urandom_range(0, 3) != 0)
                send_item(ACT_DATA, len[7:0]);
            else
            begin
                send_item(ACT_DATA, {1'b1, len[14:8]});
                send_item(ACT_DATA, len[7:0]);
            end
        end
        else
        begin
            send_item(ACT_DATA, len[7:0]);
            send_item(ACT_DATA, len[15:8]);
        end
        if (!cfg_binary)
        begin
            send_item(ACT_DATA, rgb[7:0]);
            send_item(ACT_DATA, rgb[15:8]);
        end
    endtask

    // Fetch the rest of the current run, optionally with stray beats mixed in
    task automatic drain_run(input bit noisy);
        while (pend_px != 0)
        begin
            if (noisy && $urandom_range(0, 99) < 10)
                send_item(($urandom_range(0, 1) != 0) ? ACT_DATA : ACT_END, 8'($urandom));
            else
                send_item(ACT_CONTINUE, 8'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // Segment side: stall generator and checker
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            result_stall = 1'b1;
            hold_left--;
        end
        else if (steady)
            result_stall = 1'b0;
        else
            result_stall = ($urandom_range(0, 99) < 6);
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            segments_seen++;
            if (segments_due.size() == 0)
            begin
                $display("%0t: segment expected none got %h", $time, result);
                errors++;
            end
            else
            begin
                want = segments_due.pop_front();
                check_field("write_address", 32'(want.write_address),
                            32'(result.write_address));
                check_field("pixel_count", 32'(want.pixel_count), 32'(result.pixel_count));
                check_field("pixel_color", 32'(want.pixel_color), 32'(result.pixel_color));
                check_field("more_pending", 32'(want.more_pending),
                            32'(result.more_pending));
                check_field("frame_done", 32'(want.frame_done), 32'(result.frame_done));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Items before any start are dropped; then a frame at the reset registers
    task automatic test_before_start();
        send_item(ACT_DATA, 8'h05);
        send_item(ACT_END, 8'hFF);
        send_item(ACT_CONTINUE, 8'h00);
        send_item(ACT_START, 8'($urandom));
        frames_started++;
        send_item(ACT_DATA, 8'h00);      // empty run still flips to white
        send_item(ACT_DATA, 8'h7F);
        send_item(ACT_DATA, 8'h83);      // runs over two row ends
        send_item(ACT_DATA, 8'h00);
        drain_run(1'b0);
    endtask

    // Varint lengths at their extremes, clipping, beats after a full frame
    task automatic test_varint_lengths();
        set_picture(16, 16, 20, 0, 1, 1);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_item(ACT_DATA, 8'h7F);
        drain_run(1'b0);
        send_item(ACT_DATA, 8'h80);      // two-byte zero length
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_DATA, 8'h81);      // clipped to what is left
        send_item(ACT_DATA, 8'h00);
        drain_run(1'b0);
        send_item(ACT_DATA, 8'h05);
        send_item(ACT_END, 8'h00);
        send_item(ACT_CONTINUE, 8'h00);
        // oversize width, widest segment, address at the top of the space
        set_picture(4095, 1, 4096, 20'hFFFFF, 1, 1);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_item(ACT_DATA, 8'hFF);
        send_item(ACT_DATA, 8'hFF);
    endtask

    // u16 lengths with explicit colours, partial tokens dropped by end
    task automatic test_u16_colour();
        set_picture(7, 3, 7, 20'hFFFFA, 0, 0);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_run(16'h0000, 16'hFFFF);
        send_run(16'h0003, 16'h0000);
        send_run(16'hFFFF, 16'hFFFF);
        drain_run(1'b0);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_item(ACT_DATA, 8'h12);
        send_item(ACT_END, 8'h00);
        drain_run(1'b0);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_item(ACT_DATA, 8'h02);
        send_item(ACT_DATA, 8'h00);
        send_item(ACT_DATA, 8'h34);      // colour cut short
        send_item(ACT_END, 8'h00);
        drain_run(1'b0);
    endtask

    // Beats while a run is pending, start over a pending run, pitch below width
    task automatic test_pending_run();
        set_picture(4, 4, 2, 100, 1, 1);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_item(ACT_DATA, 8'h0A);
        send_item(ACT_DATA, 8'h03);
        send_item(ACT_END, 8'h00);
        send_item(ACT_CONTINUE, 8'hA5);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_item(ACT_DATA, 8'h03);
        send_item(ACT_END, 8'h00);
        drain_run(1'b0);
        send_item(ACT_CONTINUE, 8'h00);
    endtask

    // Zero width, zero height, and a long run into the largest frame
    task automatic test_odd_sizes();
        set_picture(0, 0, 1, 0, 1, 1);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_item(ACT_DATA, 8'h05);
        send_item(ACT_END, 8'h00);
        set_picture(0, 3, 1, 0, 1, 1);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_item(ACT_DATA, 8'h02);
        drain_run(1'b0);
        send_item(ACT_END, 8'h00);
        set_picture(4095, 4095, 4096, 20'hFFFFF, 0, 1);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_run(16'h7FFF, 16'h5AA5);
        drain_run(1'b0);
    endtask

    // Registers rewritten between runs of one frame take effect at once
    task automatic test_midframe_config();
        set_picture(6, 5, 10, 1000, 0, 1);
        send_item(ACT_START, 8'h00);
        frames_started++;
        send_run(16'd8, 16'h1234);
        drain_run(1'b0);
        settle();
        write_reg(CFG_LINE_PITCH, 6);
        write_reg(CFG_VARINT_MODE, 0);
        write_reg(CFG_BINARY_MODE, 1);
        send_run(16'd9, 16'h0000);
        drain_run(1'b0);
        send_item(ACT_END, 8'h00);
        drain_run(1'b0);
    endtask

    // Hold the segment side off while continues keep coming
    task automatic test_backpressure();
        set_picture(8, 48, 8, 0, 1, 1);
        steady = 1'b1;
        send_item(ACT_START, 8'h00);
        frames_started++;
        hold_request = HOLD_CYCLES;
        send_item(ACT_DATA, 8'h81);
        send_item(ACT_DATA, 8'h40);
        drain_run(1'b0);
        send_item(ACT_END, 8'h00);
        drain_run(1'b0);
        settle();
        steady = 1'b0;
    endtask

    function automatic logic [RUN_BITS-1:0] random_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            return RUN_BITS'($urandom_range(0, 12));
        if (pick < 85)
            return RUN_BITS'($urandom_range(0, 60));
        if (pick < 95)
            return RUN_BITS'($urandom_range(0, 400));
        return RUN_BITS'($urandom);
    endfunction

    // Random frames: mostly well-formed token streams, some noise and breakage
    task automatic test_random_frames();
        int base;
        int frame_no;
        int pick;
        int w;
        int h;
        int pitch;
        base     = items_used;
        frame_no = 0;
        while (items_used - base < RANDOM_ITEMS)
        begin
            steady = (frame_no >= 8 && frame_no < 14);
            pick = $urandom_range(0, 99);
            if (pick < 85)
                w = $urandom_range(1, 24);
            else if (pick < 90)
                w = 0;
            else if (pick < 95)
                w = 4095;
            else
                w = $urandom_range(25, 2048);
            pick = $urandom_range(0, 99);
            if (pick < 85)
                h = $urandom_range(1, 6);
            else if (pick < 92)
                h = 0;
            else
                h = $urandom_range(7, 40);
            pick = $urandom_range(0, 99);
            if (pick < 70)
                pitch = (w < 1 ? 1 : w) + $urandom_range(0, 16);
            else if (pick < 90)
                pitch = $urandom_range(1, 4096);
            else
                pitch = ($urandom_range(0, 1) != 0) ? 4096 : 1;
            if (pitch > 4096)
                pitch = 4096;
            set_picture(w, h, pitch, $urandom_range(0, 20'hFFFFF),
                        $urandom_range(0, 1), $urandom_range(0, 1));
            send_item(ACT_START, 8'($urandom));
            frames_started++;
            repeat ($urandom_range(1, 12))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    send_run(random_length(), 16'($urandom));
                    // now and then leave the run pending
                    if ($urandom_range(0, 9) != 0)
                        drain_run(1'b1);
                end
                else if (pick < 90)
                begin
                    send_item(action_t'($urandom_range(1, 3)), 8'($urandom));
                    drain_run(1'b1);
                end
                else
                    send_item(ACT_DATA, 8'($urandom));
            end
            pick = $urandom_range(0, 99);
            if (pick < 75)
            begin
                send_item(ACT_END, 8'($urandom));
                drain_run(1'b1);
            end
            if (pick < 25)
                repeat ($urandom_range(1, 4)) send_item(ACT_DATA, 8'($urandom));
            frame_no++;
        end
        steady = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        item_valid = 1'b0;
        item       = '0;
        reset_model();
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        test_before_start();
        test_varint_lengths();
        test_u16_colour();
        test_pending_run();
        test_odd_sizes();
        test_midframe_config();
        test_backpressure();
        test_random_frames();
        settle();

        $display("summary: %0d frames, %0d items acted on, %0d segments checked",
                 frames_started, items_used, segments_seen);
        $display("summary: varint and u16 lengths, implicit and explicit colour, %0d mismatches",
                 errors);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("tb: errors");
        $finish;
    end

endmodule

/* rle_frame_blit_decoder.f */
hdl/rfbd_pkg.sv
hdl/rle_frame_blit_decoder.sv
test/tb.sv
